// File: src/lowest_free_index_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Lowest free index allocator: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_INDEX_ALLOCATOR_CORE_DEFINES_SVH
`define LOWEST_FREE_INDEX_ALLOCATOR_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define LFIA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define LFIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lfia_pkg.sv
// ----------------------------------------------------------------------------
// Lowest free index allocator package
// Field widths, defaults, request kinds and status codes.
// ----------------------------------------------------------------------------
package lfia_pkg;

    // Field widths
    localparam int CNT_W  = 11;
    localparam int NUM_W  = 10;
    localparam int STAT_W = 2;

    // Default geometry of the bitmap
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_WORD_BITS   = 32;

    // Reset value of the entry count register
    localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

    // Fixed-point shift of the reciprocal used to split an entry number
    localparam int RECIP_SHIFT = 24;

    typedef logic [STAT_W-1:0] status_t;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_USED    = 2'd3;

endpackage

// File: src/lowest_free_index_allocator_core.sv
// ----------------------------------------------------------------------------
// Lowest free index allocator core
// Free: a request steps through S_DIV, S_SPLIT, S_MOD and S_OUT; one item at a time.
// Allocate: as free, plus an S_SCAN step per bitmap word scanned past the first (at most
// MAX_ENTRIES/WORD_BITS - 1); the bitmap memory returns one word a cycle.
// Rejected request: goes straight to S_OUT; no new item is taken until its result is loaded.
// Reset clears the bitmap, one word per cycle, with in_ready low; configuration writes
// are taken meanwhile.
// ----------------------------------------------------------------------------
`include "lowest_free_index_allocator_core_defines.svh"

module lowest_free_index_allocator_core #(
    parameter int MAX_ENTRIES = lfia_pkg::DEF_MAX_ENTRIES,
    parameter int WORD_BITS   = lfia_pkg::DEF_WORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write_en,
    input  logic [lfia_pkg::CNT_W-1:0] cfg_write_data,
    // request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [lfia_pkg::NUM_W-1:0] entry_number,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [lfia_pkg::NUM_W-1:0] result_number,
    output lfia_pkg::status_t         status
);

    import lfia_pkg::*;

    localparam int WORD_COUNT = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BI_W       = $clog2(WORD_BITS);
    localparam int PTR_W      = CNT_W;
    localparam int BASE_W     = PTR_W + 1;
    localparam int RECIP      = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W    = RECIP_SHIFT - 2;
    localparam int PROD_W     = PTR_W + RECIP_W;
    localparam logic [WA_W-1:0]  LAST_WORD     = WA_W'(WORD_COUNT - 1);
    localparam logic [31:0]      MAX_ENTRIES_W = 32'(MAX_ENTRIES);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Lowest clear bit of a word: {found, position}
    function automatic logic [BI_W:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BI_W:0] r;
        int            i;
        r = '0;
        for (i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = {1'b1, BI_W'(i)};
            end
        end
        return r;
    endfunction

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     entry_count_reg;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic                 kind_reg, kind_next;
    logic [PTR_W-1:0]     target_reg, target_next;
    logic [WA_W-1:0]      quo_reg, quo_next;
    logic [WA_W-1:0]      word_reg, word_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic [BI_W-1:0]      bit_reg, bit_next;
    logic [WA_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [NUM_W-1:0]     res_num_reg, res_num_next;
    status_t              res_st_reg, res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]     out_num_reg;
    status_t              out_st_reg;
    logic                 out_load;

    // Bitmap memory
    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we, mem_re;
    logic [WA_W-1:0]      mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic                 accept;
    logic [PTR_W-1:0]     cnt;
    logic [BASE_W-1:0]    cnt_ext;
    logic [PTR_W-1:0]     num_ext;
    logic [PROD_W-1:0]    prod;
    logic [BASE_W-1:0]    base_calc;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] low_mask;
    logic [BI_W:0]        fz_first;
    logic [BI_W:0]        fz_scan;
    logic [BI_W:0]        fz_sel;
    logic [BASE_W-1:0]    cand;
    logic [BASE_W-1:0]    base_step;

    // Clamp the configured count to the bitmap size
    assign cnt     = (32'(entry_count_reg) > MAX_ENTRIES_W) ? PTR_W'(MAX_ENTRIES)
                                                            : entry_count_reg;
    assign cnt_ext = BASE_W'(cnt);
    assign num_ext = PTR_W'(entry_number);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Split an entry number into word and bit with a reciprocal multiply
    assign prod      = PROD_W'(target_reg) * PROD_W'(RECIP);
    assign base_calc = BASE_W'(quo_reg) * BASE_W'(WORD_BITS);

    // Search helpers for the word under test
    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;
    assign low_mask  = bit_mask - {{(WORD_BITS-1){1'b0}}, 1'b1};
    assign fz_first  = first_zero(rd_data_reg | bit_mask | low_mask);
    assign fz_scan   = first_zero(rd_data_reg);
    assign fz_sel    = (state_reg == S_MOD) ? fz_first : fz_scan;
    assign cand      = base_reg + BASE_W'(fz_sel[BI_W-1:0]);
    assign base_step = base_reg + BASE_W'(WORD_BITS);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        kind_next     = kind_reg;
        target_next   = target_reg;
        quo_next      = quo_reg;
        word_next     = word_reg;
        base_next     = base_reg;
        bit_next      = bit_reg;
        clr_addr_next = clr_addr_reg;
        res_num_next  = res_num_reg;
        res_st_next   = res_st_reg;
        mem_we        = 1'b0;
        mem_waddr     = word_reg;
        mem_wdata     = rd_data_reg;
        mem_re        = 1'b0;
        mem_raddr     = word_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + WA_W'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = kind;
                    res_num_next = '0;
                    if (kind == KIND_ALLOC)
                    begin
                        target_next = ptr_reg;
                        if (ptr_reg == cnt)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                        else if (ptr_reg == '0 || ptr_reg > cnt)
                        begin
                            res_st_next = ST_INVALID;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        target_next = num_ext;
                        if (entry_number == '0 || num_ext >= cnt)
                        begin
                            res_st_next = ST_INVALID;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                end
            end

            S_DIV:
            begin
                quo_next   = WA_W'(prod >> RECIP_SHIFT);
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                base_next  = base_calc;
                bit_next   = BI_W'(BASE_W'(target_reg) - base_calc);
                word_next  = quo_reg;
                mem_re     = 1'b1;
                mem_raddr  = quo_reg;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                if (kind_reg == KIND_FREE)
                begin
                    mem_we       = 1'b1;
                    mem_wdata    = rd_data_reg & ~bit_mask;
                    ptr_next     = (target_reg < ptr_reg) ? target_reg : ptr_reg;
                    res_num_next = NUM_W'(target_reg);
                    res_st_next  = ST_OK;
                    state_next   = S_OUT;
                end
                else if ((rd_data_reg & bit_mask) != '0)
                begin
                    res_st_next = ST_USED;
                    state_next  = S_OUT;
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_wdata    = rd_data_reg | bit_mask;
                    res_num_next = NUM_W'(target_reg);
                    res_st_next  = ST_OK;
                    if (fz_sel[BI_W])
                    begin
                        ptr_next   = (cand >= cnt_ext) ? cnt : PTR_W'(cand);
                        state_next = S_OUT;
                    end
                    else if (base_step >= cnt_ext)
                    begin
                        ptr_next   = cnt;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        base_next  = base_step;
                        word_next  = word_reg + WA_W'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = word_reg + WA_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Test the word that arrived, fetch the one after it
                if (fz_sel[BI_W])
                begin
                    ptr_next   = (cand >= cnt_ext) ? cnt : PTR_W'(cand);
                    state_next = S_OUT;
                end
                else if (base_step >= cnt_ext)
                begin
                    ptr_next   = cnt;
                    state_next = S_OUT;
                end
                else
                begin
                    base_next  = base_step;
                    word_next  = word_reg + WA_W'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = word_reg + WA_W'(1);
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold or drop the result beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            ptr_reg         <= PTR_W'(1);
            entry_count_reg <= ENTRY_COUNT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                entry_count_reg <= cfg_write_data;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        target_reg  <= target_next;
        quo_reg     <= quo_next;
        word_reg    <= word_next;
        base_reg    <= base_next;
        bit_reg     <= bit_next;
        res_num_reg <= res_num_next;
        res_st_reg  <= res_st_next;
        if (out_load)
        begin
            out_num_reg <= res_num_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_number = out_num_reg;
    assign status        = out_st_reg;

    // Checks
    `LFIA_ASSERT_NOW(a_no_same_word_rw, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same bitmap word")
    `LFIA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is in flight")
    `LFIA_ASSERT_NEXT(a_hold_result, (state_reg == S_OUT) && out_valid && !out_ready, state_reg == S_OUT, "result dropped while output beat stalled")
    `LFIA_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK), result_number == '0, "failed request returns a nonzero number")

endmodule
